/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define EPSM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("epsm check failed");

// condition that must never be seen
`define EPSM_NEVER(lbl, cond) \
	`EPSM_ASSERT(lbl, !(cond))

`endif

/* sv/epsm_pkg.sv */
// ----------------------------------------------------------------------------
// epsm_pkg
// widths, constants and helpers of the encoder position and speed meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epsm_pkg;

	// position counter width
	localparam int CNT_W = 32;

	// bit-serial multiply runs over the bits of a 20 bit constant
	localparam int MUL_STEPS = 20;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int PROD_W = CNT_W + MUL_STEPS;
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam int DEN_W = 32;
	localparam int QUO_W = 32;

	// 60000 * 16 and 360 * 16
	localparam logic [MUL_STEPS-1:0] K_SPEED = MUL_STEPS'(960000);
	localparam logic [MUL_STEPS-1:0] K_ANGLE = MUL_STEPS'(5760);

	localparam int POS_W = 32;
	localparam int RPM_W = 24;
	localparam int ANG_W = 32;
	localparam int TICK_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_MS = 2'd0,
		REG_PPR       = 2'd1,
		REG_LED_HOLD  = 2'd2
	} cfg_reg_t;

	typedef logic [CNT_W-1:0] cnt_t;

	// magnitude of a two's complement count, most negative maps to 2^(CNT_W-1)
	function automatic cnt_t cnt_abs(cnt_t v);
		return v[CNT_W-1] ? cnt_t'(~v + cnt_t'(1)) : v;
	endfunction

endpackage

/* sv/encoder_position_speed_meter_top.sv */
// ----------------------------------------------------------------------------
// encoder_position_speed_meter_top
// x1 quadrature counter with windowed rpm and shaft angle, bit-serial math
// ----------------------------------------------------------------------------
//  channel | signals                                    | beat
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | one register write
//  in      | in_valid in_ready chan_a chan_b ms_tick clear| one pin sample
//  out     | out_valid out_ready position_count rpm_x16  | one result
//          | angle_x16 activity_on sample_done           |
//
//  an input beat runs an angle pass, and a speed pass ahead of it when a
//  speed window closes; each pass is a multiply and then a divide, both
//  on the shared shift-add multiplier and restoring divider,
//  one bit per cycle; speed is computed first, then the angle
//  reset clears all state, config registers take their defaults (100/600/50)
//  a finished result waits in the output register; the next input beat is
//  taken while it waits, and a new result is held back only until it drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_position_speed_meter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [epsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [epsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             chan_a,
	input  logic                             chan_b,
	input  logic                             ms_tick,
	input  logic                             clear,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [epsm_pkg::POS_W-1:0] position_count,
	output logic [epsm_pkg::RPM_W-1:0]       rpm_x16,
	output logic signed [epsm_pkg::ANG_W-1:0] angle_x16,
	output logic                             activity_on,
	output logic                             sample_done
);
	import epsm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,   // waiting for a pin sample
		ST_MUL,    // shift-add multiply, one constant bit per cycle
		ST_DIV,    // restoring divide, one quotient bit per cycle
		ST_SPD,    // latch speed, set up the angle pass
		ST_DONE    // hand the result to the output register
	} state_t;

	// configuration registers
	logic [TICK_W-1:0] sample_ms_q;
	logic [TICK_W-1:0] ppr_q;
	logic [TICK_W-1:0] led_hold_q;

	// counter state
	logic              prev_a_q;
	cnt_t              cnt_q;
	cnt_t              wstart_q;
	logic [TICK_W-1:0] wticks_q;
	logic [RPM_W-1:0]  speed_q;
	logic [TICK_W-1:0] hold_q;
	logic              done_q;

	// arithmetic engine
	state_t               state_q;
	logic                 angle_ph_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	cnt_t                 mag_q;
	logic                 neg_q;
	logic [TICK_W-1:0]    elapsed_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;

	// output register
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  pos_q;
	logic [RPM_W-1:0]         rpm_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic                     act_q;
	logic                     sdone_q;

	// per-sample update
	logic              in_fire;
	logic              pulse;
	cnt_t              cnt_step;
	cnt_t              cnt_new;
	cnt_t              wstart_new;
	cnt_t              delta;
	logic [TICK_W-1:0] ticks_inc;
	logic              win_end;
	logic [TICK_W-1:0] hold_dec;
	logic [TICK_W-1:0] hold_new;
	cnt_t              ang_src;

	// engine datapath
	logic [TICK_W-1:0]    ppr_eff;
	logic [MUL_CNT_W-1:0] bit_idx;
	logic [MUL_STEPS-1:0] k_sel;
	logic [MUL_STEPS-1:0] el_ext;
	logic [PROD_W-1:0]    prod_nx;
	logic [DEN_W-1:0]     den_nx;
	logic [DEN_W:0]       rem_sh;
	logic                 fits;
	logic [DEN_W:0]       rem_sub;
	logic                 quo_big;
	logic [RPM_W-1:0]     speed_sat;
	logic [ANG_W-1:0]     angle_sat;
	logic                 out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	// edge detect, count, clear, then tick and hold in that order
	assign pulse      = chan_a && !prev_a_q;
	assign cnt_step   = pulse ? (chan_b ? cnt_q + cnt_t'(1) : cnt_q - cnt_t'(1)) : cnt_q;
	assign cnt_new    = clear ? '0 : cnt_step;
	assign wstart_new = clear ? '0 : wstart_q;
	assign delta      = cnt_new - wstart_new;
	assign ticks_inc  = wticks_q + TICK_W'(1);
	assign win_end    = ms_tick && (ticks_inc >= sample_ms_q);
	assign hold_dec   = (ms_tick && (hold_q != '0)) ? hold_q - TICK_W'(1) : hold_q;
	assign hold_new   = pulse ? led_hold_q : hold_dec;

	// angle pass starts from the fresh count on accept, else from the stored one
	assign ang_src = (state_q == ST_IDLE) ? cnt_new : cnt_q;

	// zero pulses per rev acts as one
	assign ppr_eff = (ppr_q == '0) ? TICK_W'(1) : ppr_q;

	// shift-add multiply, msb of the constant first
	assign bit_idx = MUL_CNT_W'(MUL_STEPS - 1) - mul_cnt_q;
	assign k_sel   = angle_ph_q ? K_ANGLE : K_SPEED;
	assign el_ext  = MUL_STEPS'(elapsed_q);
	assign prod_nx = {prod_q[PROD_W-2:0], 1'b0} + (k_sel[bit_idx] ? PROD_W'(mag_q) : '0);
	assign den_nx  = {den_q[DEN_W-2:0], 1'b0} + (el_ext[bit_idx] ? DEN_W'(ppr_eff) : '0);

	// restoring divide step, numerator shifted out of prod_q
	assign rem_sh  = {rem_q, prod_q[PROD_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = fits ? rem_sh - {1'b0, den_q} : rem_sh;

	// saturation, any quotient bit beyond the kept word counts as overflow
	assign quo_big   = ovf_q || quo_q[QUO_W-1];
	assign speed_sat = (ovf_q || (quo_q[QUO_W-1:RPM_W] != '0)) ? '1 : quo_q[RPM_W-1:0];
	always_comb begin
		if (neg_q) begin
			angle_sat = quo_big ? {1'b1, {(ANG_W-1){1'b0}}} : ANG_W'(~quo_q + QUO_W'(1));
		end else begin
			angle_sat = quo_big ? {1'b0, {(ANG_W-1){1'b1}}} : ANG_W'(quo_q);
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ms_q <= TICK_W'(100);
			ppr_q       <= TICK_W'(600);
			led_hold_q  <= TICK_W'(50);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAMPLE_MS: sample_ms_q <= cfg_data;
				REG_PPR:       ppr_q       <= cfg_data;
				REG_LED_HOLD:  led_hold_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// counter state, engine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q    <= 1'b0;
			cnt_q       <= '0;
			wstart_q    <= '0;
			wticks_q    <= '0;
			speed_q     <= '0;
			hold_q      <= '0;
			done_q      <= 1'b0;
			state_q     <= ST_IDLE;
			angle_ph_q  <= 1'b0;
			mul_cnt_q   <= '0;
			div_cnt_q   <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			elapsed_q   <= '0;
			prod_q      <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			rpm_q       <= '0;
			ang_q       <= '0;
			act_q       <= 1'b0;
			sdone_q     <= 1'b0;
		end else begin
			// result drains independently of the engine
			if (out_load) begin
				out_valid_q <= 1'b1;
				pos_q       <= POS_W'($signed(cnt_q));
				rpm_q       <= speed_q;
				ang_q       <= angle_sat;
				act_q       <= (hold_q != '0);
				sdone_q     <= done_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						prev_a_q  <= chan_a;
						cnt_q     <= cnt_new;
						hold_q    <= hold_new;
						done_q    <= win_end;
						mul_cnt_q <= '0;
						prod_q    <= '0;
						state_q   <= ST_MUL;
						if (clear) begin
							speed_q <= '0;
						end
						if (win_end) begin
							// speed pass: |delta| * 960000 / (ppr * elapsed)
							wstart_q   <= cnt_new;
							wticks_q   <= '0;
							mag_q      <= cnt_abs(delta);
							elapsed_q  <= (ticks_inc == '0) ? TICK_W'(1) : ticks_inc;
							den_q      <= '0;
							angle_ph_q <= 1'b0;
						end else begin
							wstart_q <= wstart_new;
							if (ms_tick) begin
								wticks_q <= ticks_inc;
							end
							// angle pass: |count| * 5760 / ppr
							mag_q      <= cnt_abs(ang_src);
							neg_q      <= ang_src[CNT_W-1];
							den_q      <= DEN_W'(ppr_eff);
							angle_ph_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					prod_q    <= prod_nx;
					mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
					if (!angle_ph_q) begin
						den_q <= den_nx;
					end
					if (mul_cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
						div_cnt_q <= '0;
						rem_q     <= '0;
						quo_q     <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					prod_q    <= {prod_q[PROD_W-2:0], 1'b0};
					rem_q     <= rem_sub[DEN_W-1:0];
					quo_q     <= {quo_q[QUO_W-2:0], fits};
					ovf_q     <= ovf_q || quo_q[QUO_W-1];
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
						state_q <= angle_ph_q ? ST_DONE : ST_SPD;
					end
				end
				ST_SPD: begin
					speed_q    <= speed_sat;
					mag_q      <= cnt_abs(ang_src);
					neg_q      <= ang_src[CNT_W-1];
					den_q      <= DEN_W'(ppr_eff);
					prod_q     <= '0;
					mul_cnt_q  <= '0;
					angle_ph_q <= 1'b1;
					state_q    <= ST_MUL;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign position_count = pos_q;
	assign rpm_x16        = rpm_q;
	assign angle_x16      = ang_q;
	assign activity_on    = act_q;
	assign sample_done    = sdone_q;

endmodule

/* sv/epsm_checker.sv */
// ----------------------------------------------------------------------------
// epsm_checker
// port-level checks on the encoder position and speed meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [epsm_pkg::POS_W-1:0] position_count,
	input logic signed [epsm_pkg::ANG_W-1:0] angle_x16
);
	import epsm_pkg::*;

	// a stalled result stays offered
	`EPSM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

	// one sample at a time through the serial engine
	`EPSM_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)

	// a new result only comes out of a busy engine
	`EPSM_ASSERT(a_result_from_engine, $rose(out_valid) |-> $past(!in_ready))

	// zero count means zero angle
	`EPSM_NEVER(a_zero_angle, out_valid && (position_count == '0) && (angle_x16 != '0))

endmodule

bind encoder_position_speed_meter_top epsm_checker u_epsm_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives pin samples and register writes into the encoder position and speed
// meter, tracks the count, window, speed and hold in a shadow copy, and checks
// every result beat field by field against it or against a typed expectation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import epsm_pkg::*;

	// cycles with no beat on any channel before the run is called hung
	localparam int QUIET_LIMIT = 3000;
	// settle time after the last result
	localparam int TAIL_CYCLES = 200;
	// index that maps to no register, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int NUM_PHASES = 10;
	localparam logic [63:0] SPEED_CAP = 64'd16777215;

	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic [RPM_W-1:0]        rpm;
		logic signed [ANG_W-1:0] ang;
		logic                    act;
		logic                    done;
	} meter_reading_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic                   a;
		logic                   b;
		logic                   t;
		logic                   c;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   typed;
		meter_reading_t         expv;
	} plan_row_t;

	// dut ports
	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    chan_a;
	logic                    chan_b;
	logic                    ms_tick;
	logic                    clear;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [POS_W-1:0] position_count;
	logic [RPM_W-1:0]        rpm_x16;
	logic signed [ANG_W-1:0] angle_x16;
	logic                    activity_on;
	logic                    sample_done;

	// typed expectation that rides along with the current input beat
	logic                    cur_typed = 1'b0;
	meter_reading_t          cur_exp = '0;

	// receiver idling on or off, set per phase
	logic                    idle_on = 1'b1;
	int                      stall_left = 0;

	// shadow copy of the block state and registers, reset values
	logic                    sh_prev_a = 1'b0;
	logic [CNT_W-1:0]        sh_count = '0;
	logic [CNT_W-1:0]        sh_win_start = '0;
	logic [TICK_W-1:0]       sh_win_ticks = '0;
	logic [RPM_W-1:0]        sh_speed = '0;
	logic [15:0]             sh_hold = '0;
	logic [CFG_DATA_W-1:0]   sh_sample_ms = 16'd100;
	logic [CFG_DATA_W-1:0]   sh_ppr = 16'd600;
	logic [CFG_DATA_W-1:0]   sh_led_hold = 16'd50;

	meter_reading_t          reading_q[$];
	plan_row_t               plan_q[$];
	int                      pending = 0;
	int                      errors = 0;
	int                      quiet = 0;

	// phase table: register settings, length, tick and idle shaping
	int unsigned ph_sample [NUM_PHASES] = '{5, 1, 20, 3, 65535, 4, 0, 2, 0, 10};
	int unsigned ph_ppr    [NUM_PHASES] = '{600, 1, 1, 65535, 7, 7, 0, 100, 0, 600};
	int unsigned ph_led    [NUM_PHASES] = '{3, 0, 10, 65535, 2, 2, 1, 5, 0, 50};
	int unsigned ph_items  [NUM_PHASES] = '{150, 250, 100, 100, 100, 150, 100, 150, 150, 150};
	int unsigned ph_tick   [NUM_PHASES] = '{30, 1, 40, 50, 30, 30, 30, 40, 30, 25};
	bit          ph_idle   [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1, 1, 1, 0};

	encoder_position_speed_meter_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.chan_a         (chan_a),
		.chan_b         (chan_b),
		.ms_tick        (ms_tick),
		.clear          (clear),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.position_count (position_count),
		.rpm_x16        (rpm_x16),
		.angle_x16      (angle_x16),
		.activity_on    (activity_on),
		.sample_done    (sample_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the shadow meter by one pin sample and return its reading
	function automatic meter_reading_t meter_advance(logic a, logic b, logic t, logic c);
		logic             pulse;
		logic             done;
		logic [CNT_W-1:0] diff;
		logic [CNT_W-1:0] mag;
		logic [63:0]      ppr64;
		logic [63:0]      elapsed;
		logic [63:0]      q;
		meter_reading_t   r;
		pulse = a && !sh_prev_a;
		done = 1'b0;
		sh_prev_a = a;
		// zero pulses per rev counts as one
		ppr64 = (sh_ppr != 0) ? 64'(sh_ppr) : 64'd1;

		// x1 counting on the rising edge of a, b picks the direction
		if (pulse)
			sh_count = b ? sh_count + 1'b1 : sh_count - 1'b1;

		// clear after counting, so an edge in the same beat is lost
		if (c) begin
			sh_count = '0;
			sh_win_start = '0;
			sh_speed = '0;
		end

		if (t) begin
			sh_win_ticks = sh_win_ticks + 1'b1;
			// reaches or passes, covers a lowered or zero window length
			if (sh_win_ticks >= sh_sample_ms) begin
				diff = sh_count - sh_win_start;
				mag = diff[CNT_W-1] ? ~diff + 1'b1 : diff;
				elapsed = (sh_win_ticks != 0) ? 64'(sh_win_ticks) : 64'd1;
				q = (64'(mag) * 64'd960000) / (ppr64 * elapsed);
				sh_speed = (q > SPEED_CAP) ? RPM_W'(SPEED_CAP) : q[RPM_W-1:0];
				sh_win_start = sh_count;
				sh_win_ticks = '0;
				done = 1'b1;
			end
			if (sh_hold != 0)
				sh_hold = sh_hold - 1'b1;
		end

		// a pulse reloads the hold after the countdown
		if (pulse)
			sh_hold = sh_led_hold;

		// angle rounds toward zero and saturates to the signed 32 bit range
		mag = sh_count[CNT_W-1] ? ~sh_count + 1'b1 : sh_count;
		q = (64'(mag) * 64'd5760) / ppr64;
		if (sh_count[CNT_W-1])
			r.ang = (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		else
			r.ang = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];

		r.pos = POS_W'(sh_count);
		r.rpm = sh_speed;
		r.act = (sh_hold != 0);
		r.done = done;
		return r;
	endfunction

	function automatic void add_sample(logic a, logic b, logic t, logic c);
		plan_row_t row;
		row = '{ROW_SAMPLE, a, b, t, c, '0, '0, 1'b0, '0};
		plan_q.push_back(row);
	endfunction

	function automatic void add_typed(logic a, logic b, logic t, logic c,
		int pos, int rpm, int ang, logic act, logic done);
		plan_row_t row;
		row = '{ROW_SAMPLE, a, b, t, c, '0, '0, 1'b1, '0};
		row.expv.pos = pos;
		row.expv.rpm = RPM_W'(rpm);
		row.expv.ang = ang;
		row.expv.act = act;
		row.expv.done = done;
		plan_q.push_back(row);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '{ROW_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, idx, data, 1'b0, '0};
		plan_q.push_back(row);
	endfunction

	// present one sample beat and return at the edge that takes it
	// valid is left high so a following beat can go straight out
	task automatic put_sample(logic a, logic b, logic t, logic c, logic typed,
		meter_reading_t expv);
		in_valid <= 1'b1;
		chan_a <= a;
		chan_b <= b;
		ms_tick <= t;
		clear <= c;
		cur_typed <= typed;
		cur_exp <= expv;
		do @(posedge clk); while (!in_ready);
	endtask

	// one register write beat, valid left high for back-to-back writes
	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic hold_off(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender stops until every expected result has drained
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic check_field(string tag, longint expv, longint got);
		if (expv != got) begin
			errors++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, tag, expv, got);
		end
	endtask

	// receiver side: ready drops in random bursts while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// beat monitor: register writes, accepted samples and result checks
	always @(posedge clk) begin : scoreboard
		meter_reading_t w;
		meter_reading_t got;
		int             pushed;
		int             popped;
		pushed = 0;
		popped = 0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_MS: sh_sample_ms = cfg_data;
					REG_PPR:       sh_ppr = cfg_data;
					REG_LED_HOLD:  sh_led_hold = cfg_data;
					default:       ;
				endcase
			end

			// check before pushing, a result never belongs to a beat taken now
			if (out_valid && out_ready) begin
				popped = 1;
				if (reading_q.size() == 0) begin
					errors++;
					$display("%0t mismatch result beat expected none actual pos %0d",
						$time, position_count);
				end else begin
					w = reading_q.pop_front();
					check_field("position_count", longint'($signed(w.pos)),
						longint'(position_count));
					check_field("rpm_x16", longint'(w.rpm), longint'(rpm_x16));
					check_field("angle_x16", longint'($signed(w.ang)), longint'(angle_x16));
					check_field("activity_on", longint'(w.act), longint'(activity_on));
					check_field("sample_done", longint'(w.done), longint'(sample_done));
				end
			end

			if (in_valid && in_ready) begin
				pushed = 1;
				got = meter_advance(chan_a, chan_b, ms_tick, clear);
				reading_q.push_back(cur_typed ? cur_exp : got);
			end

			pending <= pending + pushed - popped;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	initial begin
		int        i;
		int        p;
		int        k;
		int        qph;
		bit        dir_up;
		logic      a;
		logic      b;
		logic      t;
		logic      c;
		plan_row_t row;

		// every input known from time zero, reset held low before release
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SAMPLE_MS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		chan_a <= 1'b0;
		chan_b <= 1'b0;
		ms_tick <= 1'b0;
		clear <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults 100 / 600 / 50: counting both ways, clear, clear with an edge
		add_typed(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_typed(1, 1, 0, 0, 1, 0, 9, 1, 0);
		add_typed(0, 1, 0, 0, 1, 0, 9, 1, 0);
		add_typed(1, 0, 0, 0, 0, 0, 0, 1, 0);
		add_typed(0, 0, 0, 0, 0, 0, 0, 1, 0);
		add_typed(1, 0, 0, 0, -1, 0, -9, 1, 0);
		add_typed(1, 1, 0, 0, -1, 0, -9, 1, 0);
		add_typed(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_typed(1, 1, 0, 1, 0, 0, 0, 1, 0);
		// zero window length, zero pulses per rev, zero hold
		add_reg(REG_SAMPLE_MS, 16'd0);
		add_reg(REG_PPR, 16'd0);
		add_reg(REG_LED_HOLD, 16'd0);
		add_sample(0, 0, 1, 0);
		add_sample(1, 1, 0, 0);
		add_sample(0, 0, 1, 0);
		// clear with an edge and a window end in the same beat
		add_sample(1, 0, 1, 1);
		// all registers at their top, pulse and tick together
		add_reg(REG_SAMPLE_MS, 16'hFFFF);
		add_reg(REG_PPR, 16'hFFFF);
		add_reg(REG_LED_HOLD, 16'hFFFF);
		add_sample(0, 0, 1, 0);
		add_sample(1, 1, 1, 0);
		add_sample(0, 1, 1, 0);
		// window length lowered below the ticks already counted
		add_reg(REG_SAMPLE_MS, 16'd2);
		add_sample(1, 1, 1, 0);
		add_sample(0, 0, 0, 0);
		// write to an unmapped index, then a one tick hold
		add_reg(REG_SPARE, 16'hFFFF);
		add_reg(REG_LED_HOLD, 16'd1);
		add_sample(1, 1, 0, 0);
		add_sample(0, 0, 1, 0);
		add_sample(1, 1, 1, 0);

		// walk the directed table, writes only once the block is drained
		for (i = 0; i < plan_q.size(); i++) begin
			row = plan_q[i];
			if (row.kind == ROW_WRITE) begin
				if (i == 0 || plan_q[i-1].kind != ROW_WRITE)
					wait_drained();
				put_reg(row.idx, row.data);
				if (i == plan_q.size() - 1 || plan_q[i+1].kind != ROW_WRITE)
					cfg_valid <= 1'b0;
			end else begin
				put_sample(row.a, row.b, row.t, row.c, row.typed, row.expv);
			end
		end

		// one phase with settings picked at random
		ph_sample[8] = $urandom_range(1, 8);
		ph_ppr[8] = $urandom_range(0, 65535);
		ph_led[8] = $urandom_range(0, 20);

		qph = 0;
		dir_up = 1'b1;
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			idle_on <= ph_idle[p];
			put_reg(REG_SAMPLE_MS, CFG_DATA_W'(ph_sample[p]));
			put_reg(REG_PPR, CFG_DATA_W'(ph_ppr[p]));
			put_reg(REG_LED_HOLD, CFG_DATA_W'(ph_led[p]));
			cfg_valid <= 1'b0;

			for (k = 0; k < ph_items[p]; k++) begin
				if (ph_idle[p] && $urandom_range(0, 99) < 20)
					hold_off($urandom_range(1, 5));
				if (ph_idle[p] && $urandom_range(0, 299) == 0)
					wait_drained();

				if ($urandom_range(0, 99) < 85) begin
					// quadrature walk, direction changes rarely
					if ($urandom_range(0, 99) == 0)
						dir_up = !dir_up;
					if ($urandom_range(0, 9) != 0)
						qph = dir_up ? (qph + 3) % 4 : (qph + 1) % 4;
					a = (qph == 1) || (qph == 2);
					b = (qph == 2) || (qph == 3);
					t = ($urandom_range(0, 99) < ph_tick[p]);
					c = ($urandom_range(0, 199) == 0);
				end else begin
					// noise: any pin pattern, clear and tick at random
					a = 1'($urandom_range(0, 1));
					b = 1'($urandom_range(0, 1));
					t = 1'($urandom_range(0, 1));
					c = ($urandom_range(0, 7) == 0);
				end
				put_sample(a, b, t, c, 1'b0, '0);
			end
		end

		// drain, let the block settle, then report
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && reading_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
